// ===== hw/rtl/dtpc_pkg.sv =====
// Package for the digit trie prefix conflict checker.
// Holds pool sizes, status codes and the sequencer state type; no dependencies.
package dtpc_pkg;

   localparam int NODE_COUNT = 4096;
   localparam int MAX_DIGITS = 10;
   localparam int RADIX      = 10;
   localparam int NIBBLES    = 10;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int FREE_W     = NODE_W + 1;
   localparam int ROW_W      = RADIX * NODE_W;
   localparam int PASS_W     = 2;
   localparam int META_W     = PASS_W + 1;
   localparam int IDX_W      = 4;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_CONFLICT  = 3'd1,
      ST_FULL      = 3'd2,
      ST_SKIPPED   = 3'd3,
      ST_BAD_DIGIT = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROOT,
      S_RD_LINK,
      S_LINK,
      S_CLR,
      S_RD_META,
      S_META,
      S_DONE
   } state_type;

endpackage

// ===== hw/rtl/dtpc_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on dtpc_pkg for field widths.
interface dtpc_req_if
   import dtpc_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic                      starts_new_set;
   logic [4*NIBBLES-1:0]      digit_string;
   logic [IDX_W-1:0]          digit_count;

   modport source (output valid, starts_new_set, digit_string, digit_count, input ready);
   modport sink   (input valid, starts_new_set, digit_string, digit_count, output ready);
endinterface

interface dtpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] insert_status;
   logic       set_prefix_free;

   modport source (output valid, insert_status, set_prefix_free, input ready);
   modport sink   (input valid, insert_status, set_prefix_free, output ready);
endinterface

// ===== hw/rtl/digit_trie_prefix_conflict_check_core.sv =====
// Digit trie prefix conflict checker: node pool in two synchronous memories.
// Depends on dtpc_pkg and the channel interfaces in dtpc_if.sv.
//
//   channel  dir  payload                                      handshake
//   req_ch   in   starts_new_set, digit_string, digit_count    valid/ready
//   rsp_ch   out  insert_status, set_prefix_free               valid/ready
//
// One word at a time. Per digit the walk goes read row, link, clear row when a
// node is allocated and read row, link, read meta, update when an existing
// child is followed, bounded by the one read port of each memory; the word is
// also accepted, the root cleared on a new set and the response posted. The
// longest walk follows an existing child at every digit; a new set allocates
// every node. Reset is synchronous and clears no pool row; the root row is
// cleared on a new set and each node's row on allocation. A response waiting
// on rsp_ch does not block the next request from being accepted; that word
// then holds in its last cycle until the output register frees.
module digit_trie_prefix_conflict_check_core
   import dtpc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   dtpc_req_if.sink       req_ch,
   dtpc_rsp_if.source     rsp_ch
);

   logic [ROW_W-1:0]  child_mem [NODE_COUNT];
   logic [META_W-1:0] meta_mem  [NODE_COUNT];

   logic              child_we, child_re, meta_we, meta_re;
   logic [NODE_W-1:0] child_wa, child_ra, meta_wa, meta_ra;
   logic [ROW_W-1:0]  child_wd, child_rd_ff;
   logic [META_W-1:0] meta_wd, meta_rd_ff;

   state_type            state_ff, state_in;
   logic [4*NIBBLES-1:0] digits_ff, digits_in;
   logic [IDX_W-1:0]     count_ff, count_in, idx_ff, idx_in;
   logic [NODE_W-1:0]    node_ff, node_in, child_ff, child_in;
   logic [FREE_W-1:0]    next_free_ff, next_free_in;
   logic                 set_failed_ff, set_failed_in;
   status_type           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_free_ff, rsp_free_in;

   logic                 bad_word;
   logic [3:0]           digit;
   logic                 last;
   logic [NODE_W-1:0]    slot;
   logic [ROW_W-1:0]     row_upd;
   logic [PASS_W-1:0]    pass_new;
   logic                 pool_full;

   // pool memories
   always_ff @(posedge clock) begin
      if (child_we) child_mem[child_wa] <= child_wd;
      if (child_re) child_rd_ff <= child_mem[child_ra];
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_wa] <= meta_wd;
      if (meta_re) meta_rd_ff <= meta_mem[meta_ra];
   end

   // length and digit check on the incoming word
   always_comb begin
      bad_word = (req_ch.digit_count == '0)
              || (req_ch.digit_count > IDX_W'(MAX_DIGITS))
              || (req_ch.digit_count > IDX_W'(NIBBLES));
      for (int i = 0; i < NIBBLES; i++) begin
         if ((req_ch.digit_count > IDX_W'(i)) && (req_ch.digit_string[4*i +: 4] > 4'd9))
            bad_word = 1'b1;
      end
   end

   assign digit     = digits_ff[4*idx_ff +: 4];
   assign last      = (idx_ff == count_ff - IDX_W'(1));
   assign slot      = child_rd_ff[NODE_W*digit +: NODE_W];
   assign pool_full = (next_free_ff >= FREE_W'(NODE_COUNT));
   assign pass_new  = (meta_rd_ff[PASS_W-1:0] == '1) ? meta_rd_ff[PASS_W-1:0]
                                                      : meta_rd_ff[PASS_W-1:0] + PASS_W'(1);

   always_comb begin
      for (int k = 0; k < RADIX; k++) begin
         row_upd[NODE_W*k +: NODE_W] = (digit == 4'(k)) ? next_free_ff[NODE_W-1:0]
                                                         : child_rd_ff[NODE_W*k +: NODE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_free_ff  <= FREE_W'(1);
         set_failed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_free_ff  <= next_free_in;
         set_failed_ff <= set_failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      digits_ff     <= digits_in;
      count_ff      <= count_in;
      idx_ff        <= idx_in;
      node_ff       <= node_in;
      child_ff      <= child_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   always_comb begin
      state_in      = state_ff;
      digits_in     = digits_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      node_in       = node_ff;
      child_in      = child_ff;
      next_free_in  = next_free_ff;
      set_failed_in = set_failed_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      child_we      = 1'b0;
      child_wa      = node_ff;
      child_wd      = row_upd;
      child_re      = 1'b0;
      child_ra      = node_ff;
      meta_we       = 1'b0;
      meta_wa       = child_ff;
      meta_wd       = {1'b0, pass_new};
      meta_re       = 1'b0;
      meta_ra       = child_ff;
      req_ch.ready  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               digits_in = req_ch.digit_string;
               count_in  = req_ch.digit_count;
               idx_in    = '0;
               node_in   = '0;
               state_in  = S_DONE;
               if (bad_word) begin
                  status_in = ST_BAD_DIGIT;
               end else if (req_ch.starts_new_set) begin
                  next_free_in  = FREE_W'(1);
                  set_failed_in = 1'b0;
                  state_in      = S_ROOT;
               end else if (set_failed_ff) begin
                  status_in = ST_SKIPPED;
               end else begin
                  state_in = S_RD_LINK;
               end
            end
         end
         S_ROOT: begin
            child_we = 1'b1;
            child_wa = '0;
            child_wd = '0;
            state_in = S_RD_LINK;
         end
         S_RD_LINK: begin
            child_re = 1'b1;
            state_in = S_LINK;
         end
         S_LINK: begin
            if (slot == '0) begin
               if (pool_full) begin
                  status_in     = ST_FULL;
                  set_failed_in = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  child_we     = 1'b1;
                  child_in     = next_free_ff[NODE_W-1:0];
                  next_free_in = next_free_ff + FREE_W'(1);
                  state_in     = S_CLR;
               end
            end else begin
               child_in = slot;
               state_in = S_RD_META;
            end
         end
         S_CLR: begin
            // fresh node: empty row, pass count one, mark if the word ends here
            child_we = 1'b1;
            child_wa = child_ff;
            child_wd = '0;
            meta_we  = 1'b1;
            meta_wd  = {last, PASS_W'(1)};
            if (last) begin
               status_in = ST_OK;
               state_in  = S_DONE;
            end else begin
               node_in  = child_ff;
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_RD_LINK;
            end
         end
         S_RD_META: begin
            meta_re  = 1'b1;
            state_in = S_META;
         end
         S_META: begin
            meta_we = 1'b1;
            meta_wd = {meta_rd_ff[META_W-1] | last, pass_new};
            if (meta_rd_ff[META_W-1]) begin
               status_in     = ST_CONFLICT;
               set_failed_in = 1'b1;
               state_in      = S_DONE;
            end else if (last) begin
               if (pass_new > PASS_W'(1)) begin
                  status_in     = ST_CONFLICT;
                  set_failed_in = 1'b1;
               end else begin
                  status_in = ST_OK;
               end
               state_in = S_DONE;
            end else begin
               node_in  = child_ff;
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_RD_LINK;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_free_in   = !set_failed_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.insert_status   = rsp_status_ff;
   assign rsp_ch.set_prefix_free = rsp_free_ff;

endmodule
